FILE: src/gcr_six_and_two_track_decoder_defines.svh
// Assertion macros for the six-and-two track decoder.
// Used by the top level only; no other dependencies.
`ifndef GCR_SIX_AND_TWO_TRACK_DECODER_DEFINES_SVH
`define GCR_SIX_AND_TWO_TRACK_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define GCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define GCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/gcr_pkg.sv
// Shared types, codes and tables for the six-and-two track decoder.
// No dependencies.
package gcr_pkg;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_FEED   = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  localparam logic [1:0] CFG_FORMAT    = 2'd0;
  localparam logic [1:0] CFG_MIN_NIBS  = 2'd1;

  localparam int unsigned SECTORS_PER_TRACK = 16;
  localparam int unsigned BYTES_PER_SECTOR  = 256;
  // One spare bank beyond the track receives the sector being decoded.
  localparam int unsigned BANKS      = SECTORS_PER_TRACK + 1;
  localparam int unsigned BANK_W     = $clog2(BANKS);
  localparam int unsigned STORE_W    = BANK_W + 8;
  localparam int unsigned STORE_SIZE = BANKS * BYTES_PER_SECTOR;

  localparam int unsigned TWO_BIT_SPAN = 86;
  localparam logic [8:0] DATA_LAST    = 9'd342;
  localparam logic [8:0] DATA_NIBBLES = 9'd343;

  localparam logic [7:0] NIB_D5 = 8'hD5;
  localparam logic [7:0] NIB_AA = 8'hAA;
  localparam logic [7:0] NIB_96 = 8'h96;
  localparam logic [7:0] NIB_AD = 8'hAD;
  localparam logic [7:0] NIB_DE = 8'hDE;
  localparam logic [7:0] NIB_EB = 8'hEB;

  localparam logic [15:0] MIN_NIBS_RESET = 16'd5632;
  localparam logic [15:0] ALL_FOUND      = 16'hFFFF;

  localparam logic [7:0] GCR_CODES [64] = '{
    8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
    8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
    8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
    8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
    8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
    8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
    8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
    8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff};

  localparam logic [3:0] DOS_SLOT [16] = '{
    4'h0, 4'h7, 4'he, 4'h6, 4'hd, 4'h5, 4'hc, 4'h4,
    4'hb, 4'h3, 4'ha, 4'h2, 4'h9, 4'h1, 4'h8, 4'hf};

  localparam logic [3:0] PRODOS_SLOT [16] = '{
    4'h0, 4'h8, 4'h1, 4'h9, 4'h2, 4'ha, 4'h3, 4'hb,
    4'h4, 4'hc, 4'h5, 4'hd, 4'h6, 4'he, 4'h7, 4'hf};

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  nib;
    logic [11:0] addr;
    logic [5:0]  gval;
  } item_t;

  typedef struct packed {
    logic              busy;
    logic              exec;
    logic [BANK_W-1:0] free_bank;
  } back_stat_t;

  // Six-bit value of a disk nibble, matched on its low seven bits; unknown codes give 0.
  function automatic logic [5:0] gcr_lookup(input logic [6:0] key);
    logic [5:0] v;
    v = '0;
    for (int t = 63; t >= 0; t--) begin
      if (GCR_CODES[t][6:0] == key) v = 6'(t);
    end
    return v;
  endfunction

endpackage

FILE: src/gcr_queue.sv
// Two-entry queue between the front and back parts of the decoder.
// Depends on gcr_pkg.
module gcr_queue import gcr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t pop_item_o
);

  item_t      mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_item_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

FILE: src/gcr_front.sv
// Front part: accepts input items and classifies nibbles through the GCR table.
// Depends on gcr_pkg.
module gcr_front import gcr_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  disk_nibble_i,
  input  logic [11:0] read_address_i,
  input  logic        q_full_i,
  output logic        push_o,
  output item_t       item_o
);

  assign in_ready_o = ~q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  always_comb begin
    item_o.op   = opcode_i;
    item_o.nib  = disk_nibble_i;
    item_o.addr = read_address_i;
    item_o.gval = (opcode_i == OP_FEED) ? gcr_lookup(disk_nibble_i[6:0]) : 6'd0;
  end

endmodule

FILE: src/gcr_back.sv
// Back part: parser state machine, two-bit store, banked track store and result register.
// Depends on gcr_pkg.
module gcr_back import gcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        pop_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [1:0]  track_status_o,
  output logic [15:0] sectors_found_o,
  output back_stat_t  stat_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  localparam logic [3:0] PH_HUNT_ADDR = 4'd0;
  localparam logic [3:0] PH_ADDR_AA   = 4'd1;
  localparam logic [3:0] PH_ADDR_96   = 4'd2;
  localparam logic [3:0] PH_HEADER    = 4'd3;
  localparam logic [3:0] PH_HDR_DE    = 4'd4;
  localparam logic [3:0] PH_HDR_AA    = 4'd5;
  localparam logic [3:0] PH_HUNT_DATA = 4'd6;
  localparam logic [3:0] PH_DATA_AA   = 4'd7;
  localparam logic [3:0] PH_DATA_AD   = 4'd8;
  localparam logic [3:0] PH_DATA      = 4'd9;
  localparam logic [3:0] PH_END_DE    = 4'd10;
  localparam logic [3:0] PH_END_AA    = 4'd11;
  localparam logic [3:0] PH_END_EB    = 4'd12;

  logic [1:0]  state_q, state_d;
  item_t       item_q;
  logic        fmt_q;
  logic [15:0] min_q;

  logic [3:0]  phase_q, phase_d;
  logic [8:0]  fc_q, fc_d;
  logic [7:0]  held_q, held_d;
  logic [7:0]  hdr_q [4];
  logic [7:0]  hdr_d [4];
  logic [7:0]  chain_q, chain_d;
  logic [15:0] found_q, found_d;
  logic [15:0] ncnt_q, ncnt_d;

  // Logical slot to physical bank; the free bank takes the sector in flight.
  logic [BANK_W-1:0] map_q [SECTORS_PER_TRACK];
  logic [BANK_W-1:0] free_q, free_d;
  logic [BANK_W-1:0] map_rd_q;
  logic              map_we;
  logic [3:0]        map_wa;
  logic [3:0]        sel_slot;
  logic [3:0]        map_ra;

  logic [7:0]  tb_mem [TWO_BIT_SPAN];
  logic [7:0]  tb_rd_q;
  logic        tb_we;
  logic [6:0]  tb_wa;
  logic [7:0]  tb_wd;

  logic [7:0]  trk_mem [STORE_SIZE];
  logic [7:0]  trk_rd_q;
  logic        trk_we;
  logic [STORE_W-1:0] trk_wa;
  logic [7:0]  trk_wd;

  logic [8:0]  j_now;
  logic [6:0]  k_d, k_q;
  logic [1:0]  g_d, g_q;

  logic        out_valid_q;
  logic [7:0]  rd_q, rd_d;
  logic [1:0]  status_q, status_d;
  logic [15:0] found_out_q;

  logic [7:0]  hdr3_new;
  logic [8:0]  fc_inc;
  logic [7:0]  chain_new;
  logic [1:0]  lo;
  logic [8:0]  j_ex;

  assign pop_o = (state_q == S_IDLE) && q_valid_i && (!out_valid_q || out_ready_i);

  assign sel_slot = fmt_q ? PRODOS_SLOT[hdr_q[2][3:0]] : DOS_SLOT[hdr_q[2][3:0]];
  assign map_ra   = (q_item_i.op == OP_READ) ? q_item_i.addr[11:8] : sel_slot;

  // Split the data nibble index into a two-bit group and its entry.
  always_comb begin
    j_now = fc_q - 9'(TWO_BIT_SPAN);
    if (j_now < 9'(TWO_BIT_SPAN)) begin
      g_d = 2'd0;
      k_d = 7'(j_now);
    end else if (j_now < 9'(2 * TWO_BIT_SPAN)) begin
      g_d = 2'd1;
      k_d = 7'(j_now - 9'(TWO_BIT_SPAN));
    end else begin
      g_d = 2'd2;
      k_d = 7'(j_now - 9'(2 * TWO_BIT_SPAN));
    end
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    fc_d     = fc_q;
    held_d   = held_q;
    hdr_d    = hdr_q;
    chain_d  = chain_q;
    found_d  = found_q;
    ncnt_d   = ncnt_q;
    free_d   = free_q;
    map_we   = 1'b0;
    map_wa   = sel_slot;
    tb_we    = 1'b0;
    tb_wa    = fc_q[6:0];
    trk_we   = 1'b0;
    j_ex     = fc_q - 9'(TWO_BIT_SPAN);
    trk_wa   = {free_q, j_ex[7:0]};
    rd_d     = 8'd0;
    status_d = ST_OK;
    hdr3_new = {held_q[6:0], 1'b1} & item_q.nib;
    fc_inc   = fc_q + 9'd1;
    chain_new = chain_q ^ {item_q.gval, 2'b00};
    tb_wd    = chain_new;
    case (g_q)
      2'd0:    lo = {tb_rd_q[2], tb_rd_q[3]};
      2'd1:    lo = {tb_rd_q[4], tb_rd_q[5]};
      default: lo = {tb_rd_q[6], tb_rd_q[7]};
    endcase
    trk_wd = {chain_new[7:2], lo};

    case (state_q)
      S_IDLE: begin
        if (pop_o) state_d = S_FETCH;
      end
      S_FETCH: state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_IDLE;
        case (item_q.op)
          OP_START: begin
            phase_d = PH_HUNT_ADDR;
            fc_d    = 9'd0;
            held_d  = 8'd0;
            for (int i = 0; i < 4; i++) hdr_d[i] = 8'd0;
            chain_d = 8'd0;
            found_d = 16'd0;
            ncnt_d  = 16'd0;
          end
          OP_FEED: begin
            if (ncnt_q != 16'hFFFF) ncnt_d = ncnt_q + 16'd1;
            case (phase_q)
              PH_HUNT_ADDR: if (item_q.nib == NIB_D5) phase_d = PH_ADDR_AA;
              PH_ADDR_AA: phase_d = (item_q.nib == NIB_AA) ? PH_ADDR_96 : PH_HUNT_ADDR;
              PH_ADDR_96: begin
                if (item_q.nib == NIB_96) begin
                  phase_d = PH_HEADER;
                  fc_d    = 9'd0;
                end else begin
                  phase_d = PH_HUNT_ADDR;
                end
              end
              PH_HEADER: begin
                if (!fc_q[0]) held_d = item_q.nib;
                else hdr_d[fc_q[2:1]] = hdr3_new;
                fc_d = fc_inc;
                if (fc_inc >= 9'd8) begin
                  // The checksum arrives with the last pair.
                  if ((hdr3_new == (hdr_q[0] ^ hdr_q[1] ^ hdr_q[2])) &&
                      (hdr_q[2] < 8'(SECTORS_PER_TRACK))) begin
                    phase_d = PH_HDR_DE;
                  end else begin
                    phase_d = PH_HUNT_ADDR;
                  end
                  fc_d = 9'd0;
                end
              end
              PH_HDR_DE: phase_d = (item_q.nib == NIB_DE) ? PH_HDR_AA : PH_HUNT_ADDR;
              PH_HDR_AA: phase_d = (item_q.nib == NIB_AA) ? PH_HUNT_DATA : PH_HUNT_ADDR;
              PH_HUNT_DATA: if (item_q.nib == NIB_D5) phase_d = PH_DATA_AA;
              PH_DATA_AA: phase_d = (item_q.nib == NIB_AA) ? PH_DATA_AD : PH_HUNT_ADDR;
              PH_DATA_AD: begin
                if (item_q.nib == NIB_AD) begin
                  phase_d = PH_DATA;
                  fc_d    = 9'd0;
                  chain_d = 8'd0;
                end else begin
                  phase_d = PH_HUNT_ADDR;
                end
              end
              PH_DATA: begin
                // The checksum nibble only advances the count.
                if (fc_q < DATA_LAST) begin
                  chain_d = chain_new;
                  if (fc_q < 9'(TWO_BIT_SPAN)) tb_we = 1'b1;
                  else trk_we = 1'b1;
                end
                fc_d = fc_inc;
                if (fc_inc >= DATA_NIBBLES) phase_d = PH_END_DE;
              end
              PH_END_DE: phase_d = (item_q.nib == NIB_DE) ? PH_END_AA : PH_HUNT_ADDR;
              PH_END_AA: phase_d = (item_q.nib == NIB_AA) ? PH_END_EB : PH_HUNT_ADDR;
              PH_END_EB: begin
                if (item_q.nib == NIB_EB) begin
                  // Commit by swapping the staged bank into the slot.
                  map_we  = 1'b1;
                  free_d  = map_rd_q;
                  found_d = found_q | (16'd1 << hdr_q[2][3:0]);
                end
                phase_d = PH_HUNT_ADDR;
              end
              default: phase_d = PH_HUNT_ADDR;
            endcase
          end
          OP_READ: rd_d = trk_rd_q;
          default: begin
            if (ncnt_q < min_q) status_d = ST_SHORT;
            else if (found_q != ALL_FOUND) status_d = ST_MISSING;
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fmt_q       <= 1'b0;
      min_q       <= MIN_NIBS_RESET;
      phase_q     <= PH_HUNT_ADDR;
      fc_q        <= 9'd0;
      held_q      <= 8'd0;
      for (int i = 0; i < 4; i++) hdr_q[i] <= 8'd0;
      chain_q     <= 8'd0;
      found_q     <= 16'd0;
      ncnt_q      <= 16'd0;
      for (int i = 0; i < SECTORS_PER_TRACK; i++) map_q[i] <= BANK_W'(i);
      free_q      <= BANK_W'(SECTORS_PER_TRACK);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      fc_q    <= fc_d;
      held_q  <= held_d;
      hdr_q   <= hdr_d;
      chain_q <= chain_d;
      found_q <= found_d;
      ncnt_q  <= ncnt_d;
      free_q  <= free_d;
      if (map_we) map_q[map_wa] <= free_q;
      if (cfg_we_i && cfg_index_i == CFG_FORMAT) fmt_q <= cfg_data_i[0];
      if (cfg_we_i && cfg_index_i == CFG_MIN_NIBS) min_q <= cfg_data_i;
      if (state_q == S_EXEC) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q   <= q_item_i;
      map_rd_q <= map_q[map_ra];
      k_q      <= k_d;
      g_q      <= g_d;
    end
    if (state_q == S_EXEC) begin
      rd_q        <= rd_d;
      status_q    <= status_d;
      found_out_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tb_we) tb_mem[tb_wa] <= tb_wd;
    tb_rd_q <= tb_mem[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (trk_we) trk_mem[trk_wa] <= trk_wd;
    trk_rd_q <= trk_mem[{map_rd_q, item_q.addr[7:0]}];
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rd_q;
  assign track_status_o  = status_q;
  assign sectors_found_o = found_out_q;

  always_comb begin
    stat_o.busy      = (state_q != S_IDLE);
    stat_o.exec      = (state_q == S_EXEC);
    stat_o.free_bank = free_q;
  end

endmodule

FILE: src/gcr_six_and_two_track_decoder.sv
// Six-and-two GCR track decoder. Each item passes through three steps in the back part
// (map lookup, memory read, execute); the back part takes no new item until it is
// back in its idle state and the result register is free or being read.
// Sector commit swaps a spare bank into the slot map.
// Asynchronous active-low reset: empty queue, hunt for address prolog, identity slot map.
// Track store contents are undefined after reset until sectors are committed.
`include "gcr_six_and_two_track_decoder_defines.svh"
module gcr_six_and_two_track_decoder import gcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  disk_nibble_i,
  input  logic [11:0] read_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [1:0]  track_status_o,
  output logic [15:0] sectors_found_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic       push;
  item_t      push_item;
  logic       q_full;
  logic       q_valid;
  logic       pop;
  item_t      pop_item;
  back_stat_t stat;

  assign cfg_ready_o = 1'b1;

  gcr_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .disk_nibble_i  (disk_nibble_i),
    .read_address_i (read_address_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .item_o         (push_item)
  );

  gcr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  gcr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (pop_item),
    .pop_o           (pop),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_data_o     (read_data_o),
    .track_status_o  (track_status_o),
    .sectors_found_o (sectors_found_o),
    .stat_o          (stat)
  );

  `GCR_ASSERT_NOW(a_free_bank_range, 1'b1, stat.free_bank <= BANK_W'(BANKS - 1), "free bank out of range")
  `GCR_ASSERT_NOW(a_result_from_exec, $rose(out_valid_o), $past(stat.exec), "result without execute")
  `GCR_ASSERT_NEXT(a_exec_gives_result, stat.exec, out_valid_o, "execute left no result")
  `GCR_ASSERT_NOW(a_pop_only_idle, pop, !stat.busy && q_valid, "pop while busy or empty")

endmodule
